/* hw/rtl/ptd_pkg.sv */
// Shared constants, types and command/status structs of the trial-division prime tester.
package ptd_pkg;

    // Width of the integer under test (at most the 32-bit field of the input transaction)
    localparam int VALUE_WIDTH = 32;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 8;

    // Trial divisor never passes sqrt(2^VALUE_WIDTH) + 6; keep some headroom
    localparam int DIV_W = (VALUE_WIDTH + 1) / 2 + 4;
    // Running square of the divisor
    localparam int SQ_W  = 2 * DIV_W;
    // Bit counter of the serial remainder unit (holds VALUE_WIDTH itself)
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    // Base-4 digits folded for the residue modulo three (32 digits cover up to 64 bits)
    localparam int M3_DIGITS = 32;

    // Divisor sequence constants
    localparam int D_FIRST  = 5;
    localparam int D_STEP   = 6;
    localparam int D_PAIR   = 2;
    localparam int SQ_FIRST = D_FIRST * D_FIRST;
    localparam int SQ_CONST = D_STEP * D_STEP;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_BOUND,
        ST_REM_D,
        ST_REM_D2,
        ST_FINISH
    } state_t;

    typedef enum logic {
        SEL_D,
        SEL_D2
    } div_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;       // take a new value, restart the divisor sequence
        logic     rem_start;  // start a remainder on the selected divisor
        div_sel_t sel;
        logic     step;       // advance d by six, update d*d
        logic     res_set;
        logic     res_val;
        logic     out_load;   // move the verdict into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic small_prime;      // value is two or three
        logic small_composite;  // value below two, even, or a multiple of three
        logic rem_done;
        logic rem_zero;
        logic bound_ok;         // d*d <= value
        logic out_busy;         // output register holds a transaction not taken this cycle
    } status_t;

endpackage

/* hw/rtl/prime_test_trial_division_core.sv */
// Top level of the trial-division prime tester: controller plus datapath.
// Values below four and multiples of two or three are settled at classification; otherwise
// each divisor pair tried takes a bound check and two remainders from the one-bit-a-cycle
// remainder unit, the second skipped when the pair's first divisor divides; a prime ends
// on a failed bound check. Worst case for 32-bit values is a prime near 2^32: about 10900 pairs.
// One transaction in flight; the next is taken once the verdict sits in the output register.
// Synchronous active-low reset idles the controller, the remainder unit and the output valid.
module prime_test_trial_division_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptd_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptd_pkg::OUT_DATA_W-1:0]  m_tdata    // [0] is_prime, [7:1] zero
);
    import ptd_pkg::*;

    cmd_t    cmd;
    status_t status;

    ptd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ptd_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* hw/rtl/ptd_rem.sv */
// Restoring bit-serial remainder unit: one dividend bit per cycle.
module ptd_rem (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [ptd_pkg::VALUE_WIDTH-1:0]  dividend,
    input  logic [ptd_pkg::DIV_W-1:0]        divisor,
    output logic                             done,
    output logic                             rem_zero
);
    import ptd_pkg::*;

    logic [DIV_W-1:0]       r_reg, r_next;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [DIV_W-1:0]       dv_reg, dv_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_W:0]         trial;

    // One shift-and-subtract step
    always_comb begin
        trial     = {r_reg, q_reg[VALUE_WIDTH-1]};
        r_next    = r_reg;
        q_next    = q_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            r_next    = '0;
            q_next    = dividend;
            dv_next   = divisor;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dv_reg}) begin
                r_next = DIV_W'(trial - {1'b0, dv_reg});
            end else begin
                r_next = trial[DIV_W-1:0];
            end
            q_next   = {q_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial remainder
    always_ff @(posedge aclk) begin
        r_reg  <= r_next;
        q_reg  <= q_next;
        dv_reg <= dv_next;
    end

    assign done     = done_reg;
    assign rem_zero = (r_reg == '0);

    // A finished remainder is below its divisor
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (r_reg < dv_reg))
        else $error("remainder not below divisor");

    // Busy and done never both set, and a busy unit still has bits to go
    a_busy_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg != '0) && !done_reg)
        else $error("remainder unit counter inconsistent");

endmodule

/* hw/rtl/ptd_datapath.sv */
// Datapath: value register, divisor sequence with running square, remainder unit, output register.
module ptd_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ptd_pkg::cmd_t                    cmd,
    output ptd_pkg::status_t                 status,
    input  logic [ptd_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ptd_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import ptd_pkg::*;

    logic [VALUE_WIDTH-1:0] v_reg;
    logic [DIV_W-1:0]       d_reg, d_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic                   res_reg;
    logic                   mvalid_reg, mvalid_next;
    logic                   mbit_reg;
    logic [DIV_W-1:0]       divisor;
    logic                   rem_done;
    logic                   rem_zero;

    // Sum of two residues modulo three
    function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    // Residue modulo three: 4^k is 1 mod 3, so base-4 digits are folded in a balanced tree
    function automatic logic [1:0] mod3_of(input logic [VALUE_WIDTH-1:0] v);
        logic [2*M3_DIGITS-1:0] w;
        logic [1:0]             node [M3_DIGITS];
        w = (2*M3_DIGITS)'(v);
        for (int k = 0; k < M3_DIGITS; k++) begin
            node[k] = (w[2*k +: 2] == 2'd3) ? 2'd0 : w[2*k +: 2];
        end
        for (int span = 1; span < M3_DIGITS; span = span * 2) begin
            for (int k = 0; k < M3_DIGITS; k = k + 2 * span) begin
                node[k] = mod3_add(node[k], node[k + span]);
            end
        end
        return node[0];
    endfunction

    // Captured value
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg <= s_tdata[VALUE_WIDTH-1:0];
        end
    end

    // Divisor sequence; (d+6)^2 = d^2 + 12d + 36
    always_comb begin
        d_next  = d_reg;
        sq_next = sq_reg;
        if (cmd.load) begin
            d_next  = DIV_W'(D_FIRST);
            sq_next = SQ_W'(SQ_FIRST);
        end else if (cmd.step) begin
            d_next  = d_reg + DIV_W'(D_STEP);
            sq_next = sq_reg + (SQ_W'(d_reg) << 3) + (SQ_W'(d_reg) << 2) + SQ_W'(SQ_CONST);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg  <= DIV_W'(D_FIRST);
            sq_reg <= SQ_W'(SQ_FIRST);
        end else begin
            d_reg  <= d_next;
            sq_reg <= sq_next;
        end
    end

    // Divisor select
    always_comb begin
        unique case (cmd.sel)
            SEL_D:   divisor = d_reg;
            SEL_D2:  divisor = d_reg + DIV_W'(D_PAIR);
            default: divisor = d_reg;
        endcase
    end

    ptd_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.rem_start),
        .dividend (v_reg),
        .divisor  (divisor),
        .done     (rem_done),
        .rem_zero (rem_zero)
    );

    // Verdict register
    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            res_reg <= cmd.res_val;
        end
    end

    // Output register
    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else begin
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            mbit_reg <= res_reg;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, mbit_reg};

    // Status back to the controller
    always_comb begin
        status.small_prime     = (v_reg == VALUE_WIDTH'(2)) || (v_reg == VALUE_WIDTH'(3));
        status.small_composite = (v_reg < VALUE_WIDTH'(2)) || !v_reg[0]
                                 || (mod3_of(v_reg) == 2'd0);
        status.rem_done        = rem_done;
        status.rem_zero        = rem_zero;
        status.bound_ok        = (sq_reg <= SQ_W'(v_reg));
        status.out_busy        = mvalid_reg && !m_tready;
    end

    // Running square tracks the divisor
    a_square: assert property (@(posedge aclk) disable iff (!aresetn)
        (2 * SQ_W)'(sq_reg) == (2 * SQ_W)'(d_reg) * (2 * SQ_W)'(d_reg))
        else $error("running square out of step with divisor");

    // Each step moves the divisor on by six, keeping it in the 6k-1 sequence
    a_six_k: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |=> (d_reg == $past(d_reg) + DIV_W'(D_STEP)))
        else $error("divisor left the 6k-1 sequence");

    // Starting a remainder clears the done flag in the next cycle
    a_rem_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rem_start |=> !rem_done)
        else $error("stale remainder seen after start");

endmodule

/* hw/rtl/ptd_ctrl.sv */
// Controller state machine sequencing the classification and the divisor-pair trials.
module ptd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ptd_pkg::status_t  status,
    output ptd_pkg::cmd_t     cmd
);
    import ptd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                if (status.small_prime || status.small_composite) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND: begin
                state_next = status.bound_ok ? ST_REM_D : ST_FINISH;
            end
            ST_REM_D: begin
                if (status.rem_done) begin
                    state_next = status.rem_zero ? ST_FINISH : ST_REM_D2;
                end
            end
            ST_REM_D2: begin
                if (status.rem_done) begin
                    state_next = status.rem_zero ? ST_FINISH : ST_BOUND;
                end
            end
            ST_FINISH: begin
                if (!status.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.rem_start = 1'b0;
        cmd.sel       = SEL_D;
        cmd.step      = 1'b0;
        cmd.res_set   = 1'b0;
        cmd.res_val   = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CLASSIFY: begin
                if (status.small_prime) begin
                    cmd.res_set = 1'b1;
                    cmd.res_val = 1'b1;
                end else if (status.small_composite) begin
                    cmd.res_set = 1'b1;
                end
            end
            ST_BOUND: begin
                if (status.bound_ok) begin
                    cmd.rem_start = 1'b1;
                    cmd.sel       = SEL_D;
                end else begin
                    cmd.res_set = 1'b1;
                    cmd.res_val = 1'b1;
                end
            end
            ST_REM_D: begin
                if (status.rem_done) begin
                    if (status.rem_zero) begin
                        cmd.res_set = 1'b1;
                    end else begin
                        cmd.rem_start = 1'b1;
                        cmd.sel       = SEL_D2;
                    end
                end
            end
            ST_REM_D2: begin
                cmd.sel = SEL_D2;
                if (status.rem_done) begin
                    if (status.rem_zero) begin
                        cmd.res_set = 1'b1;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                cmd.out_load = !status.out_busy;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* tb/prime_test_trial_division_core_test.sv */
// Self-checking testbench for the trial-division prime tester: directed table then random values.
`timescale 1ns / 100ps

module prime_test_trial_division_core_test;

    import ptd_pkg::*;

    // Generous ceiling: one 2^31-scale prime plus the random part, several times over
    localparam int LIMIT_CYCLES  = 4_000_000;
    localparam int RANDOM_ITEMS  = 100;
    localparam int TAIL_CYCLES   = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int IDLE_PERCENT  = 6;

    // Where the expected verdict of a stimulus row comes from
    typedef enum logic [1:0] {
        EXP_COMPOSITE,
        EXP_PRIME,
        EXP_PREDICT
    } verdict_src_t;

    typedef struct packed {
        logic [IN_DATA_W-1:0] value;
        verdict_src_t         src;
    } row_t;

    typedef struct packed {
        logic [IN_DATA_W-1:0] value;
        logic                 is_prime;
    } verdict_t;

    localparam int N_ROWS = 22;

    // Directed rows: extremes, the small fixed cases, squares on the bound, one long prime
    row_t directed_rows [N_ROWS] = '{
        '{32'd0,          EXP_COMPOSITE},
        '{32'd1,          EXP_COMPOSITE},
        '{32'd2,          EXP_PRIME},
        '{32'd3,          EXP_PRIME},
        '{32'd4,          EXP_COMPOSITE},
        '{32'd9,          EXP_COMPOSITE},
        '{32'hFFFF_FFFF,  EXP_COMPOSITE},  // multiple of three
        '{32'hFFFF_FFFE,  EXP_COMPOSITE},
        '{32'h8000_0000,  EXP_COMPOSITE},
        '{32'd5,          EXP_PRIME},
        '{32'd7,          EXP_PRIME},
        '{32'd25,         EXP_PREDICT},    // d*d equals the value
        '{32'd35,         EXP_PREDICT},
        '{32'd49,         EXP_PREDICT},    // (d+2) squared on the first pair
        '{32'd121,        EXP_PREDICT},
        '{32'd143,        EXP_PREDICT},
        '{32'd97,         EXP_PREDICT},
        '{32'd65537,      EXP_PREDICT},
        '{32'd1018081,    EXP_PREDICT},    // 1009 squared, found on the last pair tried
        '{32'hAAAA_AAAB,  EXP_PREDICT},
        '{32'h5555_5555,  EXP_PREDICT},
        '{32'h7FFF_FFFF,  EXP_PREDICT}     // large prime, longest run of the test
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // [31:0] value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [0] is_prime, [7:1] zero

    verdict_src_t          s_src = EXP_PREDICT;
    verdict_t              verdict_q [$];
    int unsigned           mismatch_count = 0;
    int unsigned           results_seen = 0;
    int unsigned           cycle_count = 0;

    prime_test_trial_division_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Primality by 6k+-1 trial division, bound kept as d <= n/d so it cannot overflow
    function automatic logic prime_verdict(input logic [IN_DATA_W-1:0] v);
        logic [63:0] n;
        logic [63:0] d;
        if (VALUE_WIDTH >= 64)
            n = 64'(v);
        else
            n = 64'(v) & ((64'd1 << VALUE_WIDTH) - 64'd1);
        if (n == 64'd2 || n == 64'd3)
            return 1'b1;
        if (n < 64'd2 || n % 64'd2 == 64'd0 || n % 64'd3 == 64'd0)
            return 1'b0;
        for (d = 64'd5; d <= n / d; d += 64'd6) begin
            if (n % d == 64'd0 || n % (d + 64'd2) == 64'd0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Record accepted values and check each result transaction against the oldest verdict
    always @(posedge aclk) begin : check_proc
        verdict_t entry;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                entry.value = s_tdata;
                case (s_src)
                    EXP_COMPOSITE: entry.is_prime = 1'b0;
                    EXP_PRIME:     entry.is_prime = 1'b1;
                    default:       entry.is_prime = prime_verdict(s_tdata);
                endcase
                verdict_q.push_back(entry);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (verdict_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result transaction, is_prime %0b",
                                            m_tdata[0]));
                end else begin
                    entry = verdict_q.pop_front();
                    if (m_tdata[0] !== entry.is_prime)
                        note_mismatch($sformatf("value %0d: is_prime expected %0b, got %0b",
                                                entry.value, entry.is_prime, m_tdata[0]));
                end
            end
        end
    end

    // Receiver back-pressure; always ready over a stretch of results
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else if (results_seen >= 40 && results_seen < 70)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive one transaction from a falling edge; returns on the falling edge after acceptance
    task automatic send_value(input logic [IN_DATA_W-1:0] v, input verdict_src_t src,
                              input bit may_idle);
        if (may_idle) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_src    <= src;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (verdict_q.size() != 0)
            @(negedge aclk);
    endtask

    // Mostly small values keep prime runs short; full-range ones carry a small factor
    function automatic logic [IN_DATA_W-1:0] random_value();
        int unsigned pick;
        int unsigned factor;
        pick = $urandom_range(99);
        if (pick < 65)
            return IN_DATA_W'($urandom_range(4095));
        if (pick < 80)
            return IN_DATA_W'($urandom_range(32'h0010_0000, 32'h0000_1000));
        case ($urandom_range(5))
            0:       factor = 2;
            1:       factor = 3;
            2:       factor = 5;
            3:       factor = 7;
            4:       factor = 11;
            default: factor = 13;
        endcase
        return IN_DATA_W'(($urandom / factor) * factor);
    endfunction

    // Stimulus
    initial begin
        int i;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < N_ROWS; i++)
            send_value(directed_rows[i].value, directed_rows[i].src, 1'b1);
        s_tvalid <= 1'b0;
        wait_drained();
        @(negedge aclk);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 30) begin
                s_tvalid <= 1'b0;
                wait_drained();
                @(negedge aclk);
            end
            send_value(random_value(), EXP_PREDICT, !(i >= 50 && i < 75));
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && verdict_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* prime_test_trial_division_core.f */
hw/rtl/ptd_pkg.sv
hw/rtl/ptd_rem.sv
hw/rtl/ptd_datapath.sv
hw/rtl/ptd_ctrl.sv
hw/rtl/prime_test_trial_division_core.sv
tb/prime_test_trial_division_core_test.sv
